// ===== hdl/ipav_pkg.sv =====
`timescale 1ns / 1ps
package ipav_pkg;

	localparam int IDX_W = 10;
	localparam int PL_W  = 11;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_STEP = 2'd1,
		ST_FULL      = 2'd2,
		ST_INDEX     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RDOUT,
		S_PCHK,
		S_SETUP,
		S_DIV,
		S_CMP,
		S_WRITE,
		S_SWEEP,
		S_DONE
	} state_t;

endpackage

// ===== hdl/ipav_req_if.sv =====
`timescale 1ns / 1ps
interface ipav_req_if #(
	parameter int COUNT_BITS = 20
);
	logic                        valid;
	logic                        ready;
	logic [1:0]                  cmd;
	logic [COUNT_BITS-1:0]       cum_count;
	logic [COUNT_BITS-1:0]       cum_weight;
	logic [ipav_pkg::IDX_W-1:0]  index;

	modport source (output valid, cmd, cum_count, cum_weight, index, input ready);
	modport sink (input valid, cmd, cum_count, cum_weight, index, output ready);
endinterface

// ===== hdl/ipav_rsp_if.sv =====
`timescale 1ns / 1ps
interface ipav_rsp_if #(
	parameter int FRAC_BITS = 16
);
	logic                       valid;
	logic                       ready;
	logic [FRAC_BITS:0]         fitted_value;
	logic [1:0]                 status;
	logic [ipav_pkg::PL_W-1:0]  points_loaded;

	modport source (output valid, fitted_value, status, points_loaded, input ready);
	modport sink (input valid, fitted_value, status, points_loaded, output ready);
endinterface

// ===== hdl/isotonic_pool_adjacent_violators_top.sv =====
`timescale 1ns / 1ps
// channel  dir  payload                                  transfer
// req      in   cmd, cum_count, cum_weight, index        valid & ready
// rsp      out  fitted_value, status, points_loaded      valid & ready
//
// clear, unused command, full store and bad index go straight to S_DONE; a read passes S_RDOUT
// a push runs S_PCHK, S_SETUP, S_DIV and S_CMP per pool step, then S_WRITE and, for a pooled run, S_SWEEP;
// its length is set by the bit-serial divider (one quotient bit a cycle) and the single
// write port of the slope memory, which rewrites the pooled run one entry a cycle
// arst_n clears the point count and control; memories need no clearing
// a result waits in the output register while the next transaction is taken in
module isotonic_pool_adjacent_violators_top #(
	parameter int MAX_POINTS = 1024,
	parameter int COUNT_BITS = 20,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	ipav_req_if.sink   req,
	ipav_rsp_if.source rsp
);
	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int LW   = $clog2(MAX_POINTS + 1);
	localparam int CMPW = LW + ipav_pkg::IDX_W;
	localparam int CNTW = $clog2(FRAC_BITS + 1);
	localparam int SW   = FRAC_BITS + 1;

	ipav_pkg::state_t state_q, state_d;

	logic [2*COUNT_BITS-1:0] cw_mem [MAX_POINTS];
	logic [SW-1:0]           slope_mem [MAX_POINTS];
	logic [2*COUNT_BITS-1:0] cw_rd_q;
	logic [SW-1:0]           slope_rd_q;
	logic [AW-1:0]           rd_addr;
	logic                    cw_we, slope_we;
	logic [AW-1:0]           slope_wa;

	logic [LW-1:0]         loaded_q;
	logic                  ov_q;
	logic [SW-1:0]         out_fv_q;
	ipav_pkg::status_t     out_st_q;
	logic [ipav_pkg::PL_W-1:0] out_pl_q;

	logic [COUNT_BITS-1:0] c_q, w_q, c0_q, w0_q, dw_q, r_q;
	logic [AW-1:0]         i_q, j_q, m_q;
	logic                  first_q;
	logic [SW-1:0]         s_q, sprev_q;
	logic [FRAC_BITS-1:0]  quo_q;
	logic [CNTW-1:0]       cnt_q;
	logic [SW-1:0]         res_fv_q;
	ipav_pkg::status_t     res_st_q;

	ipav_pkg::cmd_t        cmd;
	logic                  accept;
	logic [CMPW-1:0]       idx_ext, loaded_ext;
	logic                  full, idx_bad;
	logic [COUNT_BITS-1:0] rd_c, rd_w;
	logic [COUNT_BITS-1:0] dc, dwn;
	logic [COUNT_BITS:0]   trial;
	logic                  trial_ge;
	logic                  pool;
	logic                  out_free;

	assign cmd        = ipav_pkg::cmd_t'(req.cmd);
	assign accept     = req.valid && req.ready;
	assign idx_ext    = CMPW'(req.index);
	assign loaded_ext = CMPW'(loaded_q);
	assign idx_bad    = idx_ext >= loaded_ext;
	assign full       = loaded_q == LW'(MAX_POINTS);
	assign rd_c       = cw_rd_q[2*COUNT_BITS-1:COUNT_BITS];
	assign rd_w       = cw_rd_q[COUNT_BITS-1:0];
	assign dc         = c_q - c0_q;
	assign dwn        = w_q - w0_q;
	assign trial      = {r_q, 1'b0};
	assign trial_ge   = trial >= (COUNT_BITS+1)'(dw_q);
	assign pool       = (j_q != '0) && (sprev_q > s_q);
	assign out_free   = !ov_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ipav_pkg::S_IDLE: begin
				if (accept) begin
					state_d = ipav_pkg::S_DONE;
					if (cmd == ipav_pkg::CMD_READ && !idx_bad)
						state_d = ipav_pkg::S_RDOUT;
					else if (cmd == ipav_pkg::CMD_PUSH && !full) begin
						if (loaded_q != '0)
							state_d = ipav_pkg::S_PCHK;
						else if (req.cum_weight != '0)
							state_d = ipav_pkg::S_SETUP;
					end
				end
			end
			ipav_pkg::S_RDOUT: state_d = ipav_pkg::S_DONE;
			ipav_pkg::S_PCHK: begin
				if (first_q && w_q <= rd_w)
					state_d = ipav_pkg::S_DONE;
				else
					state_d = ipav_pkg::S_SETUP;
			end
			ipav_pkg::S_SETUP: begin
				if (c_q <= c0_q || dc >= dwn)
					state_d = ipav_pkg::S_CMP;
				else
					state_d = ipav_pkg::S_DIV;
			end
			ipav_pkg::S_DIV: begin
				if (cnt_q == CNTW'(FRAC_BITS - 1))
					state_d = ipav_pkg::S_CMP;
			end
			ipav_pkg::S_CMP: begin
				if (!pool)
					state_d = ipav_pkg::S_WRITE;
				else if (j_q == AW'(1))
					state_d = ipav_pkg::S_SETUP;
				else
					state_d = ipav_pkg::S_PCHK;
			end
			ipav_pkg::S_WRITE: begin
				state_d = (j_q == i_q) ? ipav_pkg::S_DONE : ipav_pkg::S_SWEEP;
			end
			ipav_pkg::S_SWEEP: begin
				if (m_q == i_q - AW'(1))
					state_d = ipav_pkg::S_DONE;
			end
			ipav_pkg::S_DONE: begin
				if (out_free)
					state_d = ipav_pkg::S_IDLE;
			end
			default: state_d = ipav_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		cw_we     = 1'b0;
		slope_we  = 1'b0;
		slope_wa  = i_q;
		rd_addr   = '0;
		unique case (state_q)
			ipav_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (cmd == ipav_pkg::CMD_READ)
					rd_addr = idx_ext[AW-1:0];
				else
					rd_addr = AW'(loaded_q - LW'(1));
			end
			ipav_pkg::S_CMP: rd_addr = j_q - AW'(2);
			ipav_pkg::S_WRITE: begin
				cw_we    = 1'b1;
				slope_we = 1'b1;
			end
			ipav_pkg::S_SWEEP: begin
				slope_we = 1'b1;
				slope_wa = m_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cw_we)
			cw_mem[i_q] <= {c_q, w_q};
		if (slope_we)
			slope_mem[slope_wa] <= s_q;
		cw_rd_q    <= cw_mem[rd_addr];
		slope_rd_q <= slope_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ipav_pkg::S_IDLE;
			loaded_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ipav_pkg::S_IDLE && accept && cmd == ipav_pkg::CMD_CLEAR)
				loaded_q <= '0;
			if (state_q == ipav_pkg::S_WRITE)
				loaded_q <= LW'(i_q) + LW'(1);
			if (state_q == ipav_pkg::S_DONE && out_free)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ipav_pkg::S_IDLE: begin
				res_fv_q <= '0;
				res_st_q <= ipav_pkg::ST_OK;
				c_q      <= req.cum_count;
				w_q      <= req.cum_weight;
				c0_q     <= '0;
				w0_q     <= '0;
				i_q      <= loaded_q[AW-1:0];
				j_q      <= loaded_q[AW-1:0];
				first_q  <= 1'b1;
				if (cmd == ipav_pkg::CMD_READ && idx_bad)
					res_st_q <= ipav_pkg::ST_INDEX;
				if (cmd == ipav_pkg::CMD_PUSH) begin
					if (full)
						res_st_q <= ipav_pkg::ST_FULL;
					else if (loaded_q == '0 && req.cum_weight == '0)
						res_st_q <= ipav_pkg::ST_ZERO_STEP;
				end
			end
			ipav_pkg::S_RDOUT: res_fv_q <= slope_rd_q;
			ipav_pkg::S_PCHK: begin
				c0_q    <= rd_c;
				w0_q    <= rd_w;
				sprev_q <= slope_rd_q;
				first_q <= 1'b0;
				if (first_q && w_q <= rd_w)
					res_st_q <= ipav_pkg::ST_ZERO_STEP;
			end
			ipav_pkg::S_SETUP: begin
				r_q   <= dc;
				dw_q  <= dwn;
				quo_q <= '0;
				cnt_q <= '0;
				if (c_q <= c0_q)
					s_q <= '0;
				else if (dc >= dwn)
					s_q <= SW'(1) << FRAC_BITS;
			end
			ipav_pkg::S_DIV: begin
				// restoring division, one quotient bit a cycle
				r_q   <= trial_ge ? COUNT_BITS'(trial - (COUNT_BITS+1)'(dw_q))
				                  : COUNT_BITS'(trial);
				quo_q <= {quo_q[FRAC_BITS-2:0], trial_ge};
				s_q   <= {1'b0, quo_q[FRAC_BITS-2:0], trial_ge};
				cnt_q <= cnt_q + CNTW'(1);
			end
			ipav_pkg::S_CMP: begin
				if (pool) begin
					j_q <= j_q - AW'(1);
					if (j_q == AW'(1)) begin
						c0_q <= '0;
						w0_q <= '0;
					end
				end
			end
			ipav_pkg::S_WRITE: begin
				m_q      <= j_q;
				res_fv_q <= s_q;
			end
			ipav_pkg::S_SWEEP: m_q <= m_q + AW'(1);
			ipav_pkg::S_DONE: begin
				if (out_free) begin
					out_fv_q <= res_fv_q;
					out_st_q <= res_st_q;
					out_pl_q <= ipav_pkg::PL_W'(loaded_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid         = ov_q;
	assign rsp.fitted_value  = out_fv_q;
	assign rsp.status        = out_st_q;
	assign rsp.points_loaded = out_pl_q;

	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= LW'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ipav_pkg::S_DIV |-> r_q < dw_q)
		else $error("divider remainder not below divisor");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ipav_pkg::S_SWEEP |-> m_q < i_q && j_q <= m_q)
		else $error("run rewrite outside pooled run");

	a_pool_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ipav_pkg::S_WRITE |=> loaded_q == LW'(i_q) + LW'(1))
		else $error("push did not append one point");
endmodule

// ===== tb/sv/ipav_slope_checker.sv =====
`timescale 1ns / 1ps
module ipav_slope_checker (
	input  logic  clk,
	input  logic  arst_n,
	ipav_req_if   req,
	ipav_rsp_if   rsp,
	output int    mismatches,
	output int    outstanding
);

	localparam int NPTS = 1024;

	typedef struct packed {
		logic [16:0]       fitted;
		ipav_pkg::status_t status;
		logic [10:0]       loaded;
	} slope_result_t;

	logic [19:0]   count_mem  [NPTS];
	logic [19:0]   weight_mem [NPTS];
	logic [16:0]   slope_mem  [NPTS];
	int            n_points;
	slope_result_t slope_q[$];

	function automatic logic [16:0] segment_slope(int from, int to);
		logic [63:0] c0, w0, c1, w1, dc, dw;
		c0 = (from < 0) ? 64'd0 : 64'(count_mem[from]);
		w0 = (from < 0) ? 64'd0 : 64'(weight_mem[from]);
		c1 = 64'(count_mem[to]);
		w1 = 64'(weight_mem[to]);
		if (w1 <= w0 || c1 <= c0)
			return 17'd0;
		dc = c1 - c0;
		dw = w1 - w0;
		if (dc >= dw)
			return 17'h10000;
		return 17'((dc << 16) / dw);
	endfunction

	function automatic slope_result_t fit_transaction(ipav_pkg::cmd_t cmd, logic [19:0] c,
			logic [19:0] w, logic [9:0] idx);
		slope_result_t r;
		int j;
		r = '{fitted: 17'd0, status: ipav_pkg::ST_OK, loaded: 11'd0};
		case (cmd)
			ipav_pkg::CMD_CLEAR: begin
				n_points = 0;
			end
			ipav_pkg::CMD_PUSH: begin
				if (n_points >= NPTS)
					r.status = ipav_pkg::ST_FULL;
				else if (w <= ((n_points == 0) ? 20'd0 : weight_mem[n_points-1]))
					r.status = ipav_pkg::ST_ZERO_STEP;
				else begin
					count_mem[n_points]  = c;
					weight_mem[n_points] = w;
					slope_mem[n_points]  = segment_slope(n_points - 1, n_points);
					j = n_points;
					// pool backward while the earlier slope is steeper
					while (j > 0 && slope_mem[j-1] > slope_mem[n_points]) begin
						j--;
						slope_mem[n_points] = segment_slope(j - 1, n_points);
						for (int m = j; m < n_points; m++)
							slope_mem[m] = slope_mem[n_points];
					end
					r.fitted = slope_mem[n_points];
					n_points++;
				end
			end
			ipav_pkg::CMD_READ: begin
				if (int'(idx) >= n_points)
					r.status = ipav_pkg::ST_INDEX;
				else
					r.fitted = slope_mem[idx];
			end
			default: ;
		endcase
		r.loaded = 11'(n_points);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slope_result_t got, want;
		if (!arst_n) begin
			n_points    = 0;
			mismatches  = 0;
			outstanding = 0;
			slope_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{fitted: rsp.fitted_value,
					status: ipav_pkg::status_t'(rsp.status),
					loaded: rsp.points_loaded};
				if (slope_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, got);
					mismatches++;
				end else begin
					want = slope_q.pop_front();
					if (got.fitted !== want.fitted) begin
						$display("%0t: fitted_value expected %0d actual %0d",
							$time, want.fitted, got.fitted);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
						mismatches++;
					end
					if (got.loaded !== want.loaded) begin
						$display("%0t: points_loaded expected %0d actual %0d",
							$time, want.loaded, got.loaded);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				slope_q.push_back(fit_transaction(ipav_pkg::cmd_t'(req.cmd),
					req.cum_count, req.cum_weight, req.index));
			outstanding = slope_q.size();
		end
	end

endmodule

// ===== tb/sv/isotonic_pool_adjacent_violators_top_tb.sv =====
`timescale 1ns / 1ps
module isotonic_pool_adjacent_violators_top_tb;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   sent;
	bit   calm;
	bit   hold_go;

	ipav_req_if req_ch ();
	ipav_rsp_if rsp_ch ();

	isotonic_pool_adjacent_violators_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ipav_slope_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("Mismatches found");
		$finish;
	end

	// receiver: random stalls, and long hold-offs so the block backs up
	initial begin
		int hold;
		hold = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && hold == 0) begin
				hold    = 400;
				hold_go = 1'b0;
			end
			if (hold > 0) begin
				hold--;
				rsp_ch.ready = 1'b0;
			end else
				rsp_ch.ready = calm || ($urandom_range(99) >= 12);
		end
	end

	task automatic send(ipav_pkg::cmd_t cmd, logic [19:0] c, logic [19:0] w,
			logic [9:0] idx);
		while (!calm && $urandom_range(99) < 12) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid      = 1'b1;
		req_ch.cmd        = cmd;
		req_ch.cum_count  = c;
		req_ch.cum_weight = w;
		req_ch.index      = idx;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// one clear, then a run of points with rising weight, with reads and some noise mixed in
	task automatic run_series();
		int          n, r, dw;
		logic [19:0] c, w;
		n = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
		c = '0;
		w = '0;
		send(ipav_pkg::CMD_CLEAR, 20'($urandom), 20'($urandom), 10'($urandom));
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 70) begin
				dw = $urandom_range(1, 3000);
				w  = w + 20'(dw);
				case ($urandom_range(5))
					0:       c = c - 20'($urandom_range(0, 500));
					1:       c = c + 20'(dw + $urandom_range(0, 200));
					default: c = c + 20'($urandom_range(0, dw));
				endcase
				send(ipav_pkg::CMD_PUSH, c, w, 10'($urandom));
			end else if (r < 86)
				send(ipav_pkg::CMD_READ, 20'($urandom), 20'($urandom),
					10'($urandom_range(0, k + 2)));
			else if (r < 90)
				send(ipav_pkg::CMD_READ, 20'($urandom), 20'($urandom), 10'($urandom));
			else if (r < 95)
				send(ipav_pkg::CMD_PUSH, 20'($urandom), w - 20'($urandom_range(0, 3)),
					10'($urandom));
			else if (r < 98)
				send(ipav_pkg::CMD_NONE, 20'($urandom), 20'($urandom), 10'($urandom));
			else
				send(ipav_pkg::CMD_PUSH, 20'($urandom), 20'($urandom), 10'($urandom));
		end
	endtask

	initial begin
		int          cyc;
		logic [19:0] c, w;
		calm              = 1'b0;
		hold_go           = 1'b0;
		sent              = 0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = ipav_pkg::CMD_CLEAR;
		req_ch.cum_count  = '0;
		req_ch.cum_weight = '0;
		req_ch.index      = '0;
		arst_n            = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		send(ipav_pkg::CMD_READ, '0, '0, '0);
		send(ipav_pkg::CMD_PUSH, 20'd5, 20'd0, '0);
		send(ipav_pkg::CMD_PUSH, 20'd0, 20'd10, '0);
		send(ipav_pkg::CMD_PUSH, 20'd50, 20'd20, '0);
		send(ipav_pkg::CMD_PUSH, 20'd60, 20'd20, '0);
		send(ipav_pkg::CMD_PUSH, 20'd30, 20'd40, '0);
		send(ipav_pkg::CMD_PUSH, 20'd55, 20'd100, '0);
		send(ipav_pkg::CMD_PUSH, 20'd56, 20'd1000, '0);
		send(ipav_pkg::CMD_READ, '0, '0, 10'd0);
		send(ipav_pkg::CMD_READ, '0, '0, 10'd3);
		send(ipav_pkg::CMD_READ, '0, '0, 10'd5);
		send(ipav_pkg::CMD_NONE, 20'hfffff, 20'hfffff, 10'h3ff);
		send(ipav_pkg::CMD_PUSH, 20'hfffff, 20'hfffff, '0);
		send(ipav_pkg::CMD_READ, '0, '0, 10'd6);
		send(ipav_pkg::CMD_READ, '0, '0, 10'h3ff);
		send(ipav_pkg::CMD_CLEAR, '0, '0, '0);
		send(ipav_pkg::CMD_PUSH, 20'hfffff, 20'hfffff, '0);
		send(ipav_pkg::CMD_PUSH, 20'h00001, 20'h00001, '0);
		send(ipav_pkg::CMD_CLEAR, '0, '0, '0);

		// fill the store with slopes that never fall so nothing pools
		c = '0;
		w = '0;
		for (int i = 0; i < 1024; i++) begin
			c = c + 20'(i / 2);
			w = w + 20'd1000;
			send(ipav_pkg::CMD_PUSH, c, w, '0);
		end
		send(ipav_pkg::CMD_PUSH, 20'hfffff, 20'hfffff, '0);
		send(ipav_pkg::CMD_READ, '0, '0, 10'h3ff);
		send(ipav_pkg::CMD_READ, '0, '0, 10'h2aa);
		send(ipav_pkg::CMD_READ, '0, '0, 10'h155);

		while (sent < 1200) begin
			calm = (sent >= 1060 && sent < 1120);
			if (sent >= 1130 && sent < 1150)
				hold_go = 1'b1;
			run_series();
		end
		calm         = 1'b0;
		req_ch.valid = 1'b0;

		cyc = 0;
		while (outstanding != 0 && cyc < 200_000) begin
			@(negedge clk);
			cyc++;
		end
		repeat (100) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
